// ===== rtl/sobel_pkg.sv =====
// Shared constants, types and register codes for the Sobel edge threshold block.
// No dependencies; every other file in rtl imports this package.
package sobel_pkg;

  localparam int IMG_WIDTH  = 128;
  localparam int IMG_HEIGHT = 64;

  localparam int COL_W = $clog2(IMG_WIDTH);
  localparam int ROW_W = $clog2(IMG_HEIGHT);

  localparam int PIX_W     = 8;
  localparam int THR_W     = 21;
  localparam int FC_W      = 7;
  localparam int FR_W      = 6;
  localparam int OUT_ROW_W = 6;
  localparam int OUT_COL_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam int GRAD_W = PIX_W + 2;
  localparam int SQ_W   = 2 * GRAD_W;
  localparam int LINE_W = 2 * PIX_W;

  localparam int COL_CMP_W = ((COL_W > FC_W) ? COL_W : FC_W) + 1;
  localparam int ROW_CMP_W = ((ROW_W > FR_W) ? ROW_W : FR_W) + 1;

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(10000);
  localparam logic [FC_W-1:0]  FIRST_COL_RST = FC_W'(10);
  localparam logic [FR_W-1:0]  FIRST_ROW_RST = FR_W'(4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_FIRST_COL = 2'd1,
    REG_FIRST_ROW = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [GRAD_W-1:0]    gx;
    logic [GRAD_W-1:0]    gy;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 frame_end;
  } grad_t;

  function automatic logic [GRAD_W-1:0] weigh(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
    return GRAD_W'(a) + (GRAD_W'(b) << 1) + GRAD_W'(c);
  endfunction

  function automatic logic [GRAD_W-1:0] abs_diff(input logic [GRAD_W-1:0] a,
                                                 input logic [GRAD_W-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

endpackage

// ===== rtl/sobel_if.sv =====
// Handshake interfaces for the pixel, result and configuration channels.
// Depends on sobel_pkg for the field widths.
interface sobel_pix_if;
  import sobel_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sobel_res_if;
  import sobel_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 flat_flag;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_column;
  logic                 frame_end;
  modport source (output valid, output flat_flag, output out_row, output out_column,
                  output frame_end, input ready);
  modport sink (input valid, input flat_flag, input out_row, input out_column,
                input frame_end, output ready);
endinterface

interface sobel_cfg_if;
  import sobel_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sobel_front.sv =====
// Raster counters, the combined two-line store with write forwarding, the 3x3 window
// and the gradient stage. Depends on sobel_pkg and sobel_if.
module sobel_front (
  input  logic                     clk,
  input  logic                     rst_n,
  sobel_pix_if.sink                in_bus,
  input  logic [sobel_pkg::FC_W-1:0] first_column,
  input  logic [sobel_pkg::FR_W-1:0] first_row,
  output logic                     grad_valid,
  output sobel_pkg::grad_t         grad,
  input  logic                     grad_ready
);
  import sobel_pkg::*;

  logic [COL_W-1:0]  col_cnt_r, col_cnt_nxt;
  logic [ROW_W-1:0]  row_cnt_r, row_cnt_nxt;
  logic [COL_W-1:0]  col_eff;
  logic [ROW_W-1:0]  row_eff;
  logic              accept;
  logic              in_ready;
  logic              rdy2;
  logic              s1_go;

  logic              s1_v_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [ROW_W-1:0]  s1_row_r;

  logic [LINE_W-1:0] line_mem [IMG_WIDTH];
  logic [LINE_W-1:0] rd_q_r;
  logic              fwd_hit_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic [LINE_W-1:0] line_q;
  logic [LINE_W-1:0] wr_data;
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;

  logic [PIX_W-1:0]  win_r [6];

  logic [GRAD_W-1:0] right_sum, left_sum, upper_sum, lower_sum;
  logic [COL_CMP_W-1:0] fc_eff;
  logic [ROW_CMP_W-1:0] fr_eff;
  logic              hit;
  logic [ROW_W-1:0]  centre_row;
  logic [COL_W-1:0]  centre_col;
  grad_t             grad_nxt;
  logic              s2_v_r;
  grad_t             s2_r;

  assign rdy2     = !s2_v_r || grad_ready;
  assign s1_go    = s1_v_r && rdy2;
  assign in_ready = !s1_v_r || rdy2;
  assign accept   = in_bus.valid && in_ready;
  assign in_bus.ready = in_ready;

  assign col_eff = in_bus.frame_start ? '0 : col_cnt_r;
  assign row_eff = in_bus.frame_start ? '0 : row_cnt_r;

  always_comb begin
    col_cnt_nxt = col_eff + COL_W'(1);
    row_cnt_nxt = row_eff;
    if (col_eff == COL_W'(IMG_WIDTH - 1)) begin
      col_cnt_nxt = '0;
      if (row_eff == ROW_W'(IMG_HEIGHT - 1)) begin
        row_cnt_nxt = '0;
      end else begin
        row_cnt_nxt = row_eff + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (accept) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
        fwd_hit_r <= s1_go && (s1_col_r == col_eff);
      end
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r   <= in_bus.pixel;
      s1_col_r   <= col_eff;
      s1_row_r   <= row_eff;
      fwd_data_r <= wr_data;
    end
  end

  // The upper line sits in the high byte and the middle line in the low byte.
  assign line_q  = fwd_hit_r ? fwd_data_r : rd_q_r;
  assign top     = line_q[LINE_W-1:PIX_W];
  assign mid     = line_q[PIX_W-1:0];
  assign wr_data = {mid, s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_go) begin
      line_mem[s1_col_r] <= wr_data;
    end
    if (accept) begin
      rd_q_r <= line_mem[col_eff];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_go) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_pix_r;
    end
  end

  assign right_sum = weigh(top, mid, s1_pix_r);
  assign left_sum  = weigh(win_r[0], win_r[1], win_r[2]);
  assign upper_sum = weigh(win_r[0], win_r[3], top);
  assign lower_sum = weigh(win_r[2], win_r[5], s1_pix_r);

  assign fc_eff = (first_column == '0) ? COL_CMP_W'(1) : COL_CMP_W'(first_column);
  assign fr_eff = (first_row == '0) ? ROW_CMP_W'(1) : ROW_CMP_W'(first_row);
  assign hit    = (COL_CMP_W'(s1_col_r) >= fc_eff + COL_CMP_W'(1)) &&
                  (ROW_CMP_W'(s1_row_r) >= fr_eff + ROW_CMP_W'(1));

  assign centre_row = s1_row_r - ROW_W'(1);
  assign centre_col = s1_col_r - COL_W'(1);

  always_comb begin
    grad_nxt.gx        = abs_diff(right_sum, left_sum);
    grad_nxt.gy        = abs_diff(upper_sum, lower_sum);
    grad_nxt.row       = OUT_ROW_W'(centre_row);
    grad_nxt.col       = OUT_COL_W'(centre_col);
    grad_nxt.frame_end = (s1_row_r == ROW_W'(IMG_HEIGHT - 1)) &&
                         (s1_col_r == COL_W'(IMG_WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_r <= grad_nxt;
    end
  end

  assign grad_valid = s2_v_r;
  assign grad       = s2_r;

endmodule

// ===== rtl/sobel_mag.sv =====
// Squares the gradients, adds them and compares with the threshold into the result register.
// Depends on sobel_pkg and sobel_if.
module sobel_mag (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        grad_valid,
  input  sobel_pkg::grad_t            grad,
  output logic                        grad_ready,
  input  logic [sobel_pkg::THR_W-1:0] threshold,
  sobel_res_if.source                 out_bus
);
  import sobel_pkg::*;

  logic                 s3_v_r;
  logic [SQ_W-1:0]      sqx_r, sqy_r;
  logic [OUT_ROW_W-1:0] s3_row_r;
  logic [OUT_COL_W-1:0] s3_col_r;
  logic                 s3_fe_r;
  logic                 rdy_out;
  logic [THR_W-1:0]     mag_sum;
  logic                 out_v_r;
  logic                 flat_r;
  logic [OUT_ROW_W-1:0] row_r;
  logic [OUT_COL_W-1:0] col_r;
  logic                 fe_r;

  assign rdy_out    = !out_v_r || out_bus.ready;
  assign grad_ready = !s3_v_r || rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (grad_ready) begin
        s3_v_r <= grad_valid;
      end
      if (rdy_out) begin
        out_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grad_ready) begin
      sqx_r    <= grad.gx * grad.gx;
      sqy_r    <= grad.gy * grad.gy;
      s3_row_r <= grad.row;
      s3_col_r <= grad.col;
      s3_fe_r  <= grad.frame_end;
    end
  end

  assign mag_sum = THR_W'(sqx_r) + THR_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      flat_r <= mag_sum < threshold;
      row_r  <= s3_row_r;
      col_r  <= s3_col_r;
      fe_r   <= s3_fe_r;
    end
  end

  assign out_bus.valid      = out_v_r;
  assign out_bus.flat_flag  = flat_r;
  assign out_bus.out_row    = row_r;
  assign out_bus.out_column = col_r;
  assign out_bus.frame_end  = fe_r;

endmodule

// ===== rtl/sobel_edge_threshold.sv =====
// The block takes one pixel beat per clock and keeps that rate while results drain, but a
// stalled result channel holds the input; a result beat passes the stage 1, gradient,
// square and result registers after the pixel that completes its window. The rate is set
// by the single line store, read for one pixel and written for the one before it in every
// cycle that the pipeline moves. Pixels outside the evaluated region give no result beat.
// Top level: configuration registers, sobel_front, sobel_mag; depends on sobel_pkg and sobel_if.
module sobel_edge_threshold (
  input  logic        clk,
  input  logic        rst_n,
  sobel_pix_if.sink   in_bus,
  sobel_res_if.source out_bus,
  sobel_cfg_if.sink   cfg_bus
);
  import sobel_pkg::*;

  logic [THR_W-1:0] threshold_r;
  logic [FC_W-1:0]  first_col_r;
  logic [FR_W-1:0]  first_row_r;
  logic             grad_valid;
  logic             grad_ready;
  grad_t            grad;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      first_col_r <= FIRST_COL_RST;
      first_row_r <= FIRST_ROW_RST;
    end else if (cfg_bus.valid) begin
      case (cfg_reg_t'(cfg_bus.index))
        REG_THRESHOLD: threshold_r <= cfg_bus.data;
        REG_FIRST_COL: first_col_r <= cfg_bus.data[FC_W-1:0];
        REG_FIRST_ROW: first_row_r <= cfg_bus.data[FR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sobel_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .first_column (first_col_r),
    .first_row    (first_row_r),
    .grad_valid   (grad_valid),
    .grad         (grad),
    .grad_ready   (grad_ready)
  );

  sobel_mag u_mag (
    .clk        (clk),
    .rst_n      (rst_n),
    .grad_valid (grad_valid),
    .grad       (grad),
    .grad_ready (grad_ready),
    .threshold  (threshold_r),
    .out_bus    (out_bus)
  );

`ifndef SYNTHESIS
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> (out_bus.valid && !out_bus.ready))
    else $error("input stalled without a stalled result beat");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_bus.valid)
    else $error("result beat right after reset");

  a_frame_end_place: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.frame_end) |->
      (out_bus.out_row == OUT_ROW_W'(IMG_HEIGHT - 2) &&
       out_bus.out_column == OUT_COL_W'(IMG_WIDTH - 2)))
    else $error("frame end flagged away from the last centre");
`endif

endmodule
